// File: rtl/core/bst_pkg.sv
// ----------------------------------------------------------------------------
// bst_pkg: shared types and constants of the bounded set table
// Opcode and status codes, fixed field widths, parameter defaults, the
// controller command group and the key RAM geometry helper.
// ----------------------------------------------------------------------------
package bst_pkg;

  localparam int unsigned CAPACITY_DEF  = 16;
  localparam int unsigned KEY_WIDTH_DEF = 32;
  localparam int unsigned MAX_LANES     = 16;

  localparam int unsigned OPCODE_W = 3;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned ITEM_W   = 32;
  localparam int unsigned COUNT_W  = 5;

  localparam logic [OPCODE_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_ERASE  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_LOOKUP = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_READ   = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_CLEAR  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUP      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd4;

  typedef struct packed {
    logic start;
    logic advance;
    logic finish;
  } ctl_cmd_t;

  // keys compared per cycle: a power of two, at most MAX_LANES
  function automatic int unsigned lanes_of(input int unsigned cap);
    int unsigned lanes;
    lanes = (cap > MAX_LANES) ? MAX_LANES : (32'd1 << $clog2(cap));
    return lanes;
  endfunction

endpackage

// File: rtl/core/bst_req_if.sv
// ----------------------------------------------------------------------------
// bst_req_if: request channel of the bounded set table
// Valid/ready handshake carrying opcode, key and read position.
// ----------------------------------------------------------------------------
interface bst_req_if;
  logic                          valid;
  logic                          ready;
  logic [bst_pkg::OPCODE_W-1:0]  opcode;
  logic [bst_pkg::KEY_W-1:0]     key;
  logic [bst_pkg::POS_W-1:0]     position;

  modport source (output valid, output opcode, output key, output position, input ready);
  modport sink   (input valid, input opcode, input key, input position, output ready);
endinterface

// File: rtl/core/bst_rsp_if.sv
// ----------------------------------------------------------------------------
// bst_rsp_if: response channel of the bounded set table
// Valid/ready handshake carrying status, membership, read data and size.
// ----------------------------------------------------------------------------
interface bst_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [bst_pkg::STATUS_W-1:0]  status;
  logic                          found;
  logic [bst_pkg::ITEM_W-1:0]    item_out;
  logic [bst_pkg::COUNT_W-1:0]   item_count;
  logic                          is_empty;

  modport source (output valid, output status, output found, output item_out,
                  output item_count, output is_empty, input ready);
  modport sink   (input valid, input status, input found, input item_out,
                  input item_count, input is_empty, output ready);
endinterface

// File: rtl/core/bst_ctrl.sv
// ----------------------------------------------------------------------------
// bst_ctrl: request sequencer
// Accepts a request, steps the key RAM rows through the compare lanes and
// closes the request once the response register is free.
// ----------------------------------------------------------------------------
module bst_ctrl #(
  parameter  int unsigned CAPACITY = bst_pkg::CAPACITY_DEF,
  localparam int unsigned LANES    = bst_pkg::lanes_of(CAPACITY),
  localparam int unsigned ROWS     = (CAPACITY + LANES - 1) / LANES,
  localparam int unsigned ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  logic              out_free_i,
  output bst_pkg::ctl_cmd_t cmd_o,
  output logic [ROW_W-1:0]  scan_row_o,
  output logic [ROW_W-1:0]  rd_row_o
);

  typedef enum logic {S_IDLE, S_SCAN} state_e;

  state_e             state_q, state_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic               last_row;

  assign last_row = (row_q == ROW_W'(ROWS - 1));

  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.start = 1'b1;
          row_d       = '0;
          state_d     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!last_row) begin
          cmd_o.advance = 1'b1;
          row_d         = row_q + ROW_W'(1);
        end else if (out_free_i) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign scan_row_o  = row_q;
  assign rd_row_o    = cmd_o.start ? '0 : row_q + ROW_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      row_q   <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
    end
  end

endmodule

// File: rtl/core/bst_dpath.sv
// ----------------------------------------------------------------------------
// bst_dpath: key store, compare lanes and response register
// Key RAM of rows of lanes with two registered read ports, a row-wide
// key compare with hit accumulation, entry count and the result register.
// ----------------------------------------------------------------------------
module bst_dpath #(
  parameter  int unsigned CAPACITY  = bst_pkg::CAPACITY_DEF,
  parameter  int unsigned KEY_WIDTH = bst_pkg::KEY_WIDTH_DEF,
  localparam int unsigned LANES     = bst_pkg::lanes_of(CAPACITY),
  localparam int unsigned ROWS      = (CAPACITY + LANES - 1) / LANES,
  localparam int unsigned ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bst_pkg::ctl_cmd_t             cmd_i,
  input  logic [ROW_W-1:0]              scan_row_i,
  input  logic [ROW_W-1:0]              rd_row_i,
  input  logic [bst_pkg::OPCODE_W-1:0]  req_opcode_i,
  input  logic [bst_pkg::KEY_W-1:0]     req_key_i,
  input  logic [bst_pkg::POS_W-1:0]     req_position_i,
  output logic                          out_free_o,
  output logic                          rsp_valid_o,
  input  logic                          rsp_ready_i,
  output logic [bst_pkg::STATUS_W-1:0]  rsp_status_o,
  output logic                          rsp_found_o,
  output logic [bst_pkg::ITEM_W-1:0]    rsp_item_out_o,
  output logic [bst_pkg::COUNT_W-1:0]   rsp_item_count_o,
  output logic                          rsp_is_empty_o
);

  localparam int unsigned SW     = (KEY_WIDTH < bst_pkg::KEY_W) ? KEY_WIDTH : bst_pkg::KEY_W;
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned LANE_W = $clog2(LANES);
  localparam int unsigned SLOT_W = LANE_W + ROW_W;
  localparam int unsigned IW     = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
  localparam int unsigned CMP_W  = IW + bst_pkg::POS_W;

  logic [LANES-1:0][SW-1:0]  mem_q [ROWS];
  logic [LANES-1:0][SW-1:0]  rowa_q, rowb_q;

  logic [CNT_W-1:0]              count_q, count_d;
  logic [bst_pkg::OPCODE_W-1:0]  op_q;
  logic [SW-1:0]                 key_q;
  logic                          rd_ok_q;
  logic [LANE_W-1:0]             b_lane_q;
  logic                          acc_hit_q;
  logic [IW-1:0]                 acc_slot_q;

  logic                          rsp_valid_q;
  logic [bst_pkg::STATUS_W-1:0]  rsp_status_q;
  logic                          rsp_found_q;
  logic [bst_pkg::ITEM_W-1:0]    rsp_item_q;
  logic [bst_pkg::COUNT_W-1:0]   rsp_count_q;
  logic                          rsp_empty_q;

  logic [IW-1:0]        cnt_x, top_idx, rd_idx, b_idx;
  logic                 rd_ok_d;
  logic [LANES-1:0]     lane_hit;
  logic [IW-1:0]        row_slot;
  logic                 row_hit, hit;
  logic [IW-1:0]        slot;
  logic [SW-1:0]        top_val;

  logic                          wr_en;
  logic [IW-1:0]                 wr_idx;
  logic [SW-1:0]                 wr_data;
  logic [bst_pkg::STATUS_W-1:0]  status_d;
  logic [bst_pkg::ITEM_W-1:0]    item_d;
  logic [CNT_W+bst_pkg::COUNT_W-1:0] cnt_ext;

  // second read port address: top entry for erase, entry from top for read-at
  assign cnt_x   = IW'(count_q);
  assign top_idx = cnt_x - IW'(1);
  assign rd_idx  = top_idx - IW'(req_position_i);
  assign b_idx   = (req_opcode_i == bst_pkg::OP_ERASE) ? top_idx : rd_idx;
  assign rd_ok_d = CMP_W'(req_position_i) < CMP_W'(count_q);

  always_comb begin
    logic [IW-1:0] slot_l;
    lane_hit = '0;
    row_slot = '0;
    for (int l = 0; l < LANES; l++) begin
      slot_l      = IW'({scan_row_i, LANE_W'(l)});
      lane_hit[l] = (slot_l < cnt_x) && (rowa_q[l] == key_q);
      if (lane_hit[l]) begin
        row_slot = row_slot | slot_l;
      end
    end
  end

  assign row_hit = |lane_hit;
  assign hit     = acc_hit_q | row_hit;
  assign slot    = acc_slot_q | row_slot;
  assign top_val = rowb_q[b_lane_q];

  always_comb begin
    status_d = bst_pkg::ST_OK;
    item_d   = '0;
    count_d  = count_q;
    wr_en    = 1'b0;
    wr_idx   = cnt_x;
    wr_data  = key_q;
    unique case (op_q)
      bst_pkg::OP_INSERT: begin
        if (hit) begin
          status_d = bst_pkg::ST_DUP;
        end else if (count_q == CNT_W'(CAPACITY)) begin
          status_d = bst_pkg::ST_FULL;
        end else begin
          wr_en   = 1'b1;
          count_d = count_q + CNT_W'(1);
        end
      end
      bst_pkg::OP_ERASE: begin
        if (!hit) begin
          status_d = bst_pkg::ST_NOTFOUND;
        end else begin
          wr_en   = 1'b1;
          wr_idx  = slot;
          wr_data = top_val;
          count_d = count_q - CNT_W'(1);
        end
      end
      bst_pkg::OP_LOOKUP: ;
      bst_pkg::OP_READ: begin
        if (!rd_ok_q) begin
          status_d = bst_pkg::ST_RANGE;
        end else begin
          item_d = bst_pkg::ITEM_W'(top_val);
        end
      end
      bst_pkg::OP_CLEAR: count_d = '0;
      default: ;
    endcase
  end

  assign cnt_ext = {bst_pkg::COUNT_W'(0), count_d};

  // key RAM
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish && wr_en) begin
      mem_q[wr_idx[LANE_W +: ROW_W]][wr_idx[LANE_W-1:0]] <= wr_data;
    end
    if (cmd_i.start || cmd_i.advance) begin
      rowa_q <= mem_q[rd_row_i];
    end
    if (cmd_i.start) begin
      rowb_q <= mem_q[b_idx[LANE_W +: ROW_W]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q     <= req_opcode_i;
      key_q    <= req_key_i[SW-1:0];
      rd_ok_q  <= rd_ok_d;
      b_lane_q <= b_idx[LANE_W-1:0];
    end
    if (cmd_i.finish) begin
      rsp_status_q <= status_d;
      rsp_found_q  <= hit;
      rsp_item_q   <= item_d;
      rsp_count_q  <= cnt_ext[bst_pkg::COUNT_W-1:0];
      rsp_empty_q  <= (count_d == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      acc_hit_q   <= 1'b0;
      acc_slot_q  <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        acc_hit_q  <= 1'b0;
        acc_slot_q <= '0;
      end else if (cmd_i.advance) begin
        acc_hit_q  <= hit;
        acc_slot_q <= slot;
      end
      if (cmd_i.finish) begin
        count_q     <= count_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  assign out_free_o       = !rsp_valid_q || rsp_ready_i;
  assign rsp_valid_o      = rsp_valid_q;
  assign rsp_status_o     = rsp_status_q;
  assign rsp_found_o      = rsp_found_q;
  assign rsp_item_out_o   = rsp_item_q;
  assign rsp_item_count_o = rsp_count_q;
  assign rsp_is_empty_o   = rsp_empty_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> out_free_o)
    else $error("request closed while response register occupied");

  a_unique_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.advance || cmd_i.finish) |-> $onehot0(lane_hit))
    else $error("key held in more than one slot");

  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.finish |=> $stable(count_q))
    else $error("entry count moved outside request close");

  a_rsp_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> rsp_valid_q)
    else $error("closed request left no response");
`endif

endmodule

// File: rtl/core/bounded_set_table_unit.sv
// ----------------------------------------------------------------------------
// bounded_set_table_unit: bounded set of distinct keys
// Compact key array with a count; insert, erase, lookup, read-at and clear.
//
//   channel  dir  payload
//   req_i    in   opcode[2:0], key[31:0], position[3:0]
//   rsp_o    out  status[2:0], found, item_out[31:0], item_count[4:0], is_empty
//
// A request loads key RAM row 0, then scans the rows in turn through the
// compare lanes (at most 16), the last row also updating the RAM and the
// count. Reset clears the count and the sequencer; the key RAM is not
// cleared. A response waits in its register while the next request is
// taken; that request closes only once the response has been taken.
// ----------------------------------------------------------------------------
module bounded_set_table_unit #(
  parameter  int unsigned CAPACITY  = bst_pkg::CAPACITY_DEF,
  parameter  int unsigned KEY_WIDTH = bst_pkg::KEY_WIDTH_DEF,
  localparam int unsigned LANES     = bst_pkg::lanes_of(CAPACITY),
  localparam int unsigned ROWS      = (CAPACITY + LANES - 1) / LANES,
  localparam int unsigned ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bst_req_if.sink     req_i,
  bst_rsp_if.source   rsp_o
);

  bst_pkg::ctl_cmd_t  cmd;
  logic               out_free;
  logic [ROW_W-1:0]   scan_row;
  logic [ROW_W-1:0]   rd_row;

  bst_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .out_free_i  (out_free),
    .cmd_o       (cmd),
    .scan_row_o  (scan_row),
    .rd_row_o    (rd_row)
  );

  bst_dpath #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .scan_row_i       (scan_row),
    .rd_row_i         (rd_row),
    .req_opcode_i     (req_i.opcode),
    .req_key_i        (req_i.key),
    .req_position_i   (req_i.position),
    .out_free_o       (out_free),
    .rsp_valid_o      (rsp_o.valid),
    .rsp_ready_i      (rsp_o.ready),
    .rsp_status_o     (rsp_o.status),
    .rsp_found_o      (rsp_o.found),
    .rsp_item_out_o   (rsp_o.item_out),
    .rsp_item_count_o (rsp_o.item_count),
    .rsp_is_empty_o   (rsp_o.is_empty)
  );

endmodule
